@@ rtl/core/kml_pkg.sv @@
// Shared types, codes and defaults for the k-means clustering block.
package kml_pkg;

  localparam int DEF_MAX_POINTS   = 1024;
  localparam int DEF_MAX_DIMS     = 16;
  localparam int DEF_MAX_CLUSTERS = 16;

  localparam int MODE_W     = 3;
  localparam int INDEX_W    = 14;
  localparam int VALUE_W    = 16;
  localparam int DELTA_W    = 24;
  localparam int PASSES_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int NP_W = 11;
  localparam int ND_W = 5;
  localparam int NK_W = 5;
  localparam int IT_W = 16;
  localparam int TH_W = 24;

  localparam logic [NP_W-1:0] NP_RST = NP_W'(1024);
  localparam logic [ND_W-1:0] ND_RST = ND_W'(16);
  localparam logic [NK_W-1:0] NK_RST = NK_W'(16);
  localparam logic [IT_W-1:0] IT_RST = IT_W'(16);
  localparam logic [TH_W-1:0] TH_RST = '0;

  localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_WR_POINT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WR_CENT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_START    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RD_CENT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RD_ASG   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_data;
    logic [DELTA_W-1:0]        delta;
    logic [PASSES_W-1:0]       passes_run;
    logic                      status;
  } out_item_t;

endpackage

@@ rtl/core/kml_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module kml_div #(
  parameter int NW = 27,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_r;
  logic [NW-1:0]    quo_r;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DW:0]      shl;
  logic             fits;

  assign shl  = {rem_r, quo_r[NW-1]};
  assign fits = shl >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
        cnt_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? DW'(shl - {1'b0, den_r}) : shl[DW-1:0];
        quo_r <= {quo_r[NW-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("divider restarted while busy");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r)) else $error("divider done out of turn");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && cnt_r == '0) else $error("divider failed to launch");
`endif
endmodule

@@ rtl/core/kml_sqrt.sv @@
// Digit-by-digit integer square root, rounded to nearest, one bit per cycle.
module kml_sqrt #(
  parameter int XW = 36
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [XW-1:0]   x,
  output logic            done,
  output logic [(XW+1)/2:0] root
);
  localparam int RW    = (XW + 1) / 2;
  localparam int XE    = 2 * RW;
  localparam int CNT_W = $clog2(RW + 1);

  logic [XE-1:0]    xs_r;
  logic [RW:0]      rem_r;
  logic [RW-1:0]    root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [RW+2:0]    remsh;
  logic [RW+2:0]    trial;
  logic             take;

  assign remsh = {rem_r, xs_r[XE-1:XE-2]};
  assign trial = (RW+3)'({root_r, 2'b01});
  assign take  = remsh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        xs_r   <= XE'(x);
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        xs_r   <= {xs_r[XE-3:0], 2'b00};
        rem_r  <= take ? (RW+1)'(remsh - trial) : remsh[RW:0];
        root_r <= {root_r[RW-2:0], take};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = (RW+1)'(root_r) + (RW+1)'(rem_r > {1'b0, root_r});

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("root unit restarted while busy");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r)) else $error("root unit done out of turn");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r <= {root_r, 1'b0}) else $error("root remainder out of bound");
`endif
endmodule

@@ rtl/core/kmeans_lloyd_clustering.sv @@
// Lloyd k-means clustering engine over on-chip point and centroid memories.
// Write items (point or centroid element) and other non-read, non-start items are taken one per
// cycle while idle and the output is not stalled, and answered at once; centroid and assignment
// reads pass the registered memory read port and the read state first. A start item is answered
// when its run ends, or at once with status set if the cluster count exceeds the point count. Each
// pass clears the sums and counts, then per point does the distance work and the sum accumulation
// (one element per cycle on the point memory port), then per centroid the bit-serial mean divider
// (NW = 17+log2(MAX_POINTS) steps), root unit (RW = about 18). Up to max_iters passes per start.
module kmeans_lloyd_clustering #(
  parameter int MAX_POINTS   = kml_pkg::DEF_MAX_POINTS,
  parameter int MAX_DIMS     = kml_pkg::DEF_MAX_DIMS,
  parameter int MAX_CLUSTERS = kml_pkg::DEF_MAX_CLUSTERS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  kml_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output kml_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [kml_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kml_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import kml_pkg::*;

  localparam int PDEPTH = MAX_POINTS * MAX_DIMS;
  localparam int KD     = MAX_CLUSTERS * MAX_DIMS;
  localparam int PA_W   = $clog2(PDEPTH);
  localparam int CA_W   = $clog2(KD);
  localparam int PIW    = $clog2(MAX_POINTS);
  localparam int KIW    = $clog2(MAX_CLUSTERS);
  localparam int DIW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int SW     = VALUE_W + $clog2(MAX_POINTS);
  localparam int NW     = SW + 1;
  localparam int ACC_W  = 32 + $clog2(MAX_DIMS);
  localparam int RW     = (ACC_W + 1) / 2;
  localparam int TW     = ((RW + 1) > DELTA_W) ? (RW + 2) : (DELTA_W + 1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_READ   = 13'b0000000000010,
    S_CLEAR  = 13'b0000000000100,
    S_ASSIGN = 13'b0000000001000,
    S_ADRAIN = 13'b0000000010000,
    S_ACCUM  = 13'b0000000100000,
    S_SDRAIN = 13'b0000001000000,
    S_URD    = 13'b0000010000000,
    S_ULD    = 13'b0000100000000,
    S_UWAIT  = 13'b0001000000000,
    S_UMV    = 13'b0010000000000,
    S_UACC   = 13'b0100000000000,
    S_USQ    = 13'b1000000000000
  } state_t;

  state_t state_r;

  logic [NP_W-1:0] np_cfg_r;
  logic [ND_W-1:0] nd_cfg_r;
  logic [NK_W-1:0] nk_cfg_r;
  logic [IT_W-1:0] it_cfg_r;
  logic [TH_W-1:0] th_cfg_r;

  logic signed [VALUE_W-1:0] pt_mem   [PDEPTH];
  logic signed [VALUE_W-1:0] cent_mem [KD];
  logic signed [SW-1:0]      sum_mem  [KD];
  logic [CW-1:0]             cnt_mem  [MAX_CLUSTERS];
  logic [KIW-1:0]            asg_mem  [MAX_POINTS];

  logic signed [VALUE_W-1:0] pt_q, cent_q;
  logic signed [SW-1:0]      sum_q;
  logic [CW-1:0]             cnt_q;
  logic [KIW-1:0]            asg_q;

  logic [PA_W-1:0] pt_raddr, pt_waddr;
  logic            pt_we;
  logic [CA_W-1:0] cent_raddr, cent_waddr;
  logic            cent_we;
  logic signed [VALUE_W-1:0] cent_wdata;
  logic [CA_W-1:0] sum_raddr, sum_waddr;
  logic            sum_we;
  logic signed [SW-1:0] sum_wdata;
  logic [KIW-1:0]  cnt_raddr, cnt_waddr;
  logic            cnt_we;
  logic [CW-1:0]   cnt_wdata;
  logic [PIW-1:0]  asg_raddr;
  logic            asg_we;

  logic [PIW-1:0] n_r, np_m1_r;
  logic [KIW-1:0] k_r, nk_m1_r;
  logic [DIW-1:0] d_r, nd_m1_r;
  logic [IT_W-1:0] it_r, pass_r;
  logic [CA_W-1:0] clr_r;

  logic v1_r, f1_r, l1_r, v2_r, f2_r, l2_r;
  logic [KIW-1:0] k1_r, k2_r, bestk_r;
  logic [31:0] prod2_r, prod_r;
  logic [ACC_W-1:0] acc_r, best_r, accn, sq_acc_r, sq_nxt;

  logic av_r, a_cnt_r, fwd_v_r;
  logic [CA_W-1:0] a_addr_r, fwd_addr_r;
  logic signed [SW-1:0] fwd_data_r, sum_old, sum_new;

  logic s_neg_r, czero_r;
  logic signed [VALUE_W-1:0] old_r, newv, q16;
  logic [DELTA_W-1:0] total_r, tot_new, last_delta_r;
  logic [PASSES_W-1:0] last_passes_r, pass_nxt;

  logic out_valid_r;
  out_item_t out_r;
  logic rd_cent_r, rd_asg_r;

  logic in_acc, bad_cfg, pt_ok, cent_ok, asg_ok;
  int np_c, nd_c, nk_c;
  logic [CA_W-1:0] addr_k, addr_b;
  logic signed [VALUE_W:0] diff_a, diff_u;
  logic signed [2*VALUE_W+1:0] sq_a, sq_u;
  logic [SW-1:0] mag;
  logic div_start, div_done, sq_start, sq_done;
  logic [NW-1:0] div_num, quot;
  logic [RW:0] root;
  logic [TW-1:0] tsum;

  assign in_stall = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    np_c = (np_cfg_r == '0) ? 1 : ((int'(np_cfg_r) > MAX_POINTS) ? MAX_POINTS : int'(np_cfg_r));
    nd_c = (nd_cfg_r == '0) ? 1 : ((int'(nd_cfg_r) > MAX_DIMS) ? MAX_DIMS : int'(nd_cfg_r));
    nk_c = (nk_cfg_r == '0) ? 1 :
           ((int'(nk_cfg_r) > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(nk_cfg_r));
  end

  assign bad_cfg = nk_c > np_c;
  assign pt_ok   = int'(in_data.index) < PDEPTH;
  assign cent_ok = int'(in_data.index) < KD;
  assign asg_ok  = int'(in_data.index) < MAX_POINTS;

  assign addr_k = CA_W'(k_r) * CA_W'(MAX_DIMS) + CA_W'(d_r);
  assign addr_b = CA_W'(bestk_r) * CA_W'(MAX_DIMS) + CA_W'(d_r);

  // memory ports
  always_comb begin
    pt_raddr   = PA_W'(n_r) * PA_W'(MAX_DIMS) + PA_W'(d_r);
    pt_waddr   = PA_W'(in_data.index);
    pt_we      = (state_r == S_IDLE) && in_acc && (in_data.mode == MODE_WR_POINT) && pt_ok;
    cent_raddr = (state_r == S_IDLE) ? CA_W'(in_data.index) : addr_k;
    cent_we    = 1'b0;
    cent_waddr = addr_k;
    cent_wdata = newv;
    if (state_r == S_UMV) begin
      cent_we = 1'b1;
    end else if (in_acc && (in_data.mode == MODE_WR_CENT) && cent_ok) begin
      cent_we    = 1'b1;
      cent_waddr = CA_W'(in_data.index);
      cent_wdata = in_data.value;
    end
    sum_raddr = (state_r == S_ACCUM) ? addr_b : addr_k;
    cnt_raddr = (state_r == S_ACCUM) ? bestk_r : k_r;
    asg_raddr = PIW'(in_data.index);
    asg_we    = (state_r == S_ACCUM) && (d_r == '0);
    sum_we    = 1'b0;
    sum_waddr = a_addr_r;
    sum_wdata = sum_new;
    cnt_we    = 1'b0;
    cnt_waddr = bestk_r;
    cnt_wdata = cnt_q + 1'b1;
    if (state_r == S_CLEAR) begin
      sum_we    = 1'b1;
      sum_waddr = clr_r;
      sum_wdata = '0;
      cnt_we    = int'(clr_r) < MAX_CLUSTERS;
      cnt_waddr = clr_r[KIW-1:0];
      cnt_wdata = '0;
    end else if (av_r) begin
      sum_we = 1'b1;
      cnt_we = a_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_waddr] <= in_data.value;
    pt_q <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (cent_we) cent_mem[cent_waddr] <= cent_wdata;
    cent_q <= cent_mem[cent_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_q <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (asg_we) asg_mem[n_r] <= bestk_r;
    asg_q <= asg_mem[asg_raddr];
  end

  // datapath
  assign diff_a  = {pt_q[VALUE_W-1], pt_q} - {cent_q[VALUE_W-1], cent_q};
  assign sq_a    = diff_a * diff_a;
  assign accn    = (f2_r ? '0 : acc_r) + ACC_W'(prod2_r);
  assign sum_old = (fwd_v_r && (fwd_addr_r == a_addr_r)) ? fwd_data_r : sum_q;
  assign sum_new = sum_old + SW'(pt_q);
  assign mag     = sum_q[SW-1] ? SW'(-sum_q) : sum_q;
  assign div_num = NW'(mag) + NW'(cnt_q >> 1);
  assign div_start = (state_r == S_ULD) && (cnt_q != '0);
  assign q16     = quot[VALUE_W-1:0];
  assign newv    = czero_r ? old_r : (s_neg_r ? -q16 : q16);
  assign diff_u  = {newv[VALUE_W-1], newv} - {old_r[VALUE_W-1], old_r};
  assign sq_u    = diff_u * diff_u;
  assign sq_nxt  = ((d_r == '0) ? '0 : sq_acc_r) + ACC_W'(prod_r);
  assign sq_start = (state_r == S_UACC) && (d_r == nd_m1_r);
  assign tsum    = TW'(total_r) + TW'(root);
  assign tot_new = (tsum > TW'(DELTA_MAX)) ? DELTA_MAX : tsum[DELTA_W-1:0];
  assign pass_nxt = pass_r + 1'b1;

  kml_div #(.NW(NW), .DW(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(cnt_q),
    .done(div_done), .quot(quot)
  );

  kml_sqrt #(.XW(ACC_W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .x(sq_nxt), .done(sq_done), .root(root)
  );

  // distance and accumulation pipelines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      av_r    <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      v1_r    <= state_r == S_ASSIGN;
      v2_r    <= v1_r;
      av_r    <= state_r == S_ACCUM;
      fwd_v_r <= av_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_r <= d_r == '0;
    l1_r <= d_r == nd_m1_r;
    k1_r <= k_r;
    f2_r <= f1_r;
    l2_r <= l1_r;
    k2_r <= k1_r;
    prod2_r <= sq_a[31:0];
    if (v2_r) begin
      acc_r <= accn;
      if (l2_r && ((k2_r == '0) || (accn < best_r))) begin
        best_r  <= accn;
        bestk_r <= k2_r;
      end
    end
    a_addr_r   <= addr_b;
    a_cnt_r    <= d_r == '0;
    fwd_addr_r <= a_addr_r;
    fwd_data_r <= sum_new;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      np_cfg_r <= NP_RST;
      nd_cfg_r <= ND_RST;
      nk_cfg_r <= NK_RST;
      it_cfg_r <= IT_RST;
      th_cfg_r <= TH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_POINTS:   np_cfg_r <= cfg_data[NP_W-1:0];
        CFG_NUM_DIMS:     nd_cfg_r <= cfg_data[ND_W-1:0];
        CFG_NUM_CLUSTERS: nk_cfg_r <= cfg_data[NK_W-1:0];
        CFG_MAX_ITERS:    it_cfg_r <= cfg_data[IT_W-1:0];
        CFG_THRESHOLD:    th_cfg_r <= cfg_data[TH_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      last_delta_r  <= '0;
      last_passes_r <= '0;
    end else begin
      if (out_valid_r && !out_stall && !in_acc) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            out_r.read_data  <= '0;
            out_r.delta      <= last_delta_r;
            out_r.passes_run <= last_passes_r;
            out_r.status     <= (in_data.mode == MODE_START) && bad_cfg;
            rd_cent_r        <= (in_data.mode == MODE_RD_CENT) && cent_ok;
            rd_asg_r         <= (in_data.mode == MODE_RD_ASG) && asg_ok;
            case (in_data.mode)
              MODE_START: begin
                if (bad_cfg) begin
                  out_valid_r <= 1'b1;
                end else begin
                  out_valid_r <= 1'b0;
                  np_m1_r <= PIW'(np_c - 1);
                  nd_m1_r <= DIW'(nd_c - 1);
                  nk_m1_r <= KIW'(nk_c - 1);
                  it_r    <= (it_cfg_r == '0) ? IT_W'(1) : it_cfg_r;
                  pass_r  <= '0;
                  clr_r   <= '0;
                  state_r <= S_CLEAR;
                end
              end
              MODE_RD_CENT, MODE_RD_ASG: begin
                out_valid_r <= 1'b0;
                state_r     <= S_READ;
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_READ: begin
          out_r.read_data <= rd_cent_r ? cent_q : (rd_asg_r ? VALUE_W'(asg_q) : '0);
          out_valid_r     <= 1'b1;
          state_r         <= S_IDLE;
        end
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CA_W'(KD - 1)) begin
            n_r     <= '0;
            k_r     <= '0;
            d_r     <= '0;
            total_r <= '0;
            state_r <= S_ASSIGN;
          end
        end
        S_ASSIGN: begin
          if (d_r == nd_m1_r) begin
            d_r <= '0;
            if (k_r == nk_m1_r) state_r <= S_ADRAIN;
            else k_r <= k_r + 1'b1;
          end else begin
            d_r <= d_r + 1'b1;
          end
        end
        S_ADRAIN: begin
          if (!v1_r && !v2_r) state_r <= S_ACCUM;
        end
        S_ACCUM: begin
          if (d_r == nd_m1_r) state_r <= S_SDRAIN;
          else d_r <= d_r + 1'b1;
        end
        S_SDRAIN: begin
          k_r <= '0;
          d_r <= '0;
          if (n_r == np_m1_r) begin
            state_r <= S_URD;
          end else begin
            n_r     <= n_r + 1'b1;
            state_r <= S_ASSIGN;
          end
        end
        S_URD: state_r <= S_ULD;
        S_ULD: begin
          s_neg_r <= sum_q[SW-1];
          czero_r <= cnt_q == '0;
          old_r   <= cent_q;
          state_r <= (cnt_q == '0) ? S_UMV : S_UWAIT;
        end
        S_UWAIT: begin
          if (div_done) state_r <= S_UMV;
        end
        S_UMV: begin
          prod_r  <= sq_u[31:0];
          state_r <= S_UACC;
        end
        S_UACC: begin
          sq_acc_r <= sq_nxt;
          if (d_r == nd_m1_r) begin
            state_r <= S_USQ;
          end else begin
            d_r     <= d_r + 1'b1;
            state_r <= S_URD;
          end
        end
        S_USQ: begin
          if (sq_done) begin
            total_r <= tot_new;
            d_r     <= '0;
            if (k_r == nk_m1_r) begin
              last_delta_r  <= tot_new;
              last_passes_r <= pass_nxt;
              pass_r        <= pass_nxt;
              if ((tot_new < th_cfg_r) || (pass_nxt == it_r)) begin
                out_r.read_data  <= '0;
                out_r.delta      <= tot_new;
                out_r.passes_run <= pass_nxt;
                out_r.status     <= 1'b0;
                out_valid_r      <= 1'b1;
                state_r          <= S_IDLE;
              end else begin
                clr_r   <= '0;
                state_r <= S_CLEAR;
              end
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_URD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state register not one-hot");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == S_IDLE && !(out_valid_r && out_stall))
    else $error("item taken while busy");
  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r)) else $error("distance stage out of order");
  a_accum_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_URD |-> !av_r) else $error("sum update still pending at mean step");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> state_r == S_IDLE) else $error("result raised during run");
`endif
endmodule
